// File: rtl/core/blendshape_vertex_reconstruct_assert.svh
// Assertion macros for the blendshape reconstruction block.
// Needs a clock and an active-low reset name passed in by the user.
`ifndef BLENDSHAPE_VERTEX_RECONSTRUCT_ASSERT_SVH
`define BLENDSHAPE_VERTEX_RECONSTRUCT_ASSERT_SVH

// Same-cycle implication.
`define BVR_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BVR_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bvr_pkg.sv
// Shared types and constants for the blendshape reconstruction block.
// No dependencies; imported by bvr_coef_bank, the top level of the block and the testbench.
`default_nettype none

package bvr_pkg;

	localparam int ELEM_W       = 10;
	localparam int MAX_ELEMENTS = 1 << ELEM_W;
	localparam int MODE_W       = 6;
	localparam int MAX_MODES    = 1 << MODE_W;
	localparam int MODE_CNT_W   = MODE_W + 1;
	localparam int BASIS_AW     = MODE_W + ELEM_W;
	localparam int BASIS_DEPTH  = MAX_MODES * MAX_ELEMENTS;
	localparam int VAL_W        = 16;
	localparam int PROD_W       = 2 * VAL_W;
	localparam int FRAC_W       = 12;
	localparam int ACC_W        = 40;
	localparam int POS_W        = 32;
	localparam int ECOUNT_W     = ELEM_W + 1;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = ECOUNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY_MODES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPRESSION_MODES = 2'd2;

	localparam logic BANK_IDENTITY   = 1'b0;
	localparam logic BANK_EXPRESSION = 1'b1;

	typedef enum logic [1:0] {
		REQ_NEUTRAL = 2'd0,
		REQ_BASIS   = 2'd1,
		REQ_COEFF   = 2'd2,
		REQ_QUERY   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		req_kind_t                 req_type;
		logic                      bank_select;
		logic [MODE_W-1:0]         mode_index;
		logic [ELEM_W-1:0]         element_index;
		logic signed [VAL_W-1:0]   value;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0]         element_out;
		logic signed [POS_W-1:0]   position;
		logic                      out_of_range;
	} result_t;

	typedef struct packed {
		logic                      we;
		logic [MODE_W-1:0]         addr;
		logic signed [VAL_W-1:0]   data;
	} coef_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/bvr_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module bvr_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: rtl/core/bvr_coef_bank.sv
// Coefficient store for one basis bank, cleared to zero by valid bits at reset.
// Depends on bvr_pkg.
`default_nettype none

module bvr_coef_bank (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bvr_pkg::coef_wr_t                wr,
	input  wire logic [bvr_pkg::MODE_W-1:0]       rd_addr,
	output logic signed [bvr_pkg::VAL_W-1:0]      rd_data
);

	import bvr_pkg::*;

	logic signed [VAL_W-1:0] mem [MAX_MODES];
	logic [MAX_MODES-1:0]    valid_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/blendshape_vertex_reconstruct.sv
// Top level of the blendshape reconstruction block: sequencer, memories, MAC.
// Depends on bvr_pkg, bvr_ram, bvr_coef_bank and the assertion macro header.
//
// Usage: an item on req is taken at a clock edge where start is high and busy
// is low. Neutral, basis and coefficient writes are stored at that edge and
// leave busy low, so a write can follow every cycle. A query raises busy and
// walks the modes in use, reading one identity and one expression basis entry
// plus their coefficients per cycle from the memories and accumulating both
// products. With N = max(identity modes, expression modes), each clamped to 64
// and at least 1, N modes are walked and busy stays high through the finish
// state. An index at or past element_count gives out_of_range with position
// zero. Results sit in an output register, flagged by done for exactly one
// cycle as busy falls; the receiver cannot stall and the next item may be
// taken in that same cycle. Configuration uses cfg_we, cfg_index and cfg_data,
// written only while idle by the user; the block does not enforce it. Reset
// clears the configuration registers, the sequencer and all coefficients to
// zero; neutral and basis memories hold nothing defined until written.
`default_nettype none
`include "blendshape_vertex_reconstruct_assert.svh"

module blendshape_vertex_reconstruct (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire bvr_pkg::req_t                    req,
	output logic                                  done,
	output bvr_pkg::result_t                      result,
	input  wire logic                             cfg_we,
	input  wire logic [bvr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bvr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import bvr_pkg::*;

	state_t state_q, state_d;

	logic [ECOUNT_W-1:0]    element_count_q;
	logic [MODE_CNT_W-1:0]  identity_modes_q;
	logic [MODE_CNT_W-1:0]  expression_modes_q;

	logic [MODE_CNT_W-1:0]  mode_q;
	logic [ELEM_W-1:0]      elem_q;
	logic                   oor_q;

	logic                   accept;
	logic                   query_in;
	logic                   in_range;
	logic [MODE_CNT_W-1:0]  n_id, n_ex, n_max;
	logic                   id_v, ex_v, last_slot;

	logic                   run_s1, last_s1, id_v_s1, ex_v_s1;
	logic                   valid_s2, last_s2;
	logic signed [PROD_W-1:0] prod_id_s2, prod_ex_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;

	logic                   done_q;
	result_t                result_q;

	logic [ELEM_W-1:0]      neutral_addr;
	logic [VAL_W-1:0]       neutral_rd;
	logic [BASIS_AW-1:0]    basis_addr;
	logic [VAL_W-1:0]       id_basis_rd, ex_basis_rd;
	logic signed [VAL_W-1:0] id_coef_rd, ex_coef_rd;
	logic                   neutral_we, id_basis_we, ex_basis_we;
	coef_wr_t               id_coef_wr, ex_coef_wr;

	assign accept   = start && !busy;
	assign query_in = accept && (req.req_type == REQ_QUERY);
	assign in_range = {1'b0, req.element_index} < element_count_q;

	assign n_id  = (identity_modes_q > MODE_CNT_W'(MAX_MODES)) ?
		MODE_CNT_W'(MAX_MODES) : identity_modes_q;
	assign n_ex  = (expression_modes_q > MODE_CNT_W'(MAX_MODES)) ?
		MODE_CNT_W'(MAX_MODES) : expression_modes_q;
	assign n_max = (n_id > n_ex) ? n_id : n_ex;
	assign id_v  = mode_q < n_id;
	assign ex_v  = mode_q < n_ex;
	assign last_slot = (mode_q + MODE_CNT_W'(1)) >= n_max;

	// Memories
	assign neutral_we   = accept && (req.req_type == REQ_NEUTRAL);
	assign neutral_addr = req.element_index;
	assign id_basis_we  = accept && (req.req_type == REQ_BASIS) &&
		(req.bank_select == BANK_IDENTITY);
	assign ex_basis_we  = accept && (req.req_type == REQ_BASIS) &&
		(req.bank_select == BANK_EXPRESSION);
	assign basis_addr   = busy ? {mode_q[MODE_W-1:0], elem_q} :
		{req.mode_index, req.element_index};

	always_comb begin
		id_coef_wr.we   = accept && (req.req_type == REQ_COEFF) &&
			(req.bank_select == BANK_IDENTITY);
		id_coef_wr.addr = req.mode_index;
		id_coef_wr.data = req.value;
		ex_coef_wr.we   = accept && (req.req_type == REQ_COEFF) &&
			(req.bank_select == BANK_EXPRESSION);
		ex_coef_wr.addr = req.mode_index;
		ex_coef_wr.data = req.value;
	end

	bvr_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(VAL_W)) u_neutral (
		.clk   (clk),
		.we    (neutral_we),
		.addr  (neutral_addr),
		.wdata (req.value),
		.rdata (neutral_rd)
	);

	bvr_ram #(.DEPTH(BASIS_DEPTH), .WIDTH(VAL_W)) u_id_basis (
		.clk   (clk),
		.we    (id_basis_we),
		.addr  (basis_addr),
		.wdata (req.value),
		.rdata (id_basis_rd)
	);

	bvr_ram #(.DEPTH(BASIS_DEPTH), .WIDTH(VAL_W)) u_ex_basis (
		.clk   (clk),
		.we    (ex_basis_we),
		.addr  (basis_addr),
		.wdata (req.value),
		.rdata (ex_basis_rd)
	);

	bvr_coef_bank u_id_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (id_coef_wr),
		.rd_addr (mode_q[MODE_W-1:0]),
		.rd_data (id_coef_rd)
	);

	bvr_coef_bank u_ex_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ex_coef_wr),
		.rd_addr (mode_q[MODE_W-1:0]),
		.rd_data (ex_coef_rd)
	);

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q    <= '0;
			identity_modes_q   <= '0;
			expression_modes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ELEMENT_COUNT:    element_count_q    <= cfg_data;
				CFG_IDENTITY_MODES:   identity_modes_q   <= cfg_data[MODE_CNT_W-1:0];
				CFG_EXPRESSION_MODES: expression_modes_q <= cfg_data[MODE_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (query_in) begin
					state_d = in_range ? ST_RUN : ST_FIN;
				end
			end
			ST_RUN: begin
				if (last_slot) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (valid_s2 && last_s2) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			run_s1   <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (query_in) begin
				mode_q <= '0;
			end else if (state_q == ST_RUN && !last_slot) begin
				mode_q <= mode_q + MODE_CNT_W'(1);
			end
			run_s1   <= (state_q == ST_RUN);
			valid_s2 <= run_s1;
			done_q   <= (state_q == ST_FIN);
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (query_in) begin
			elem_q <= req.element_index;
			oor_q  <= !in_range;
		end
		last_s1 <= last_slot;
		id_v_s1 <= id_v;
		ex_v_s1 <= ex_v;
		last_s2 <= last_s1;
		prod_id_s2 <= (id_v_s1 && id_coef_rd != '0) ?
			PROD_W'(id_coef_rd * signed'(id_basis_rd)) : '0;
		prod_ex_s2 <= (ex_v_s1 && ex_coef_rd != '0) ?
			PROD_W'(ex_coef_rd * signed'(ex_basis_rd)) : '0;
		if (state_q == ST_RUN && mode_q == '0) begin
			acc_q <= ACC_W'(signed'(neutral_rd)) <<< FRAC_W;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_id_s2) + ACC_W'(prod_ex_s2);
		end
		if (state_q == ST_FIN) begin
			result_q.element_out  <= elem_q;
			result_q.out_of_range <= oor_q;
			result_q.position     <= oor_q ? '0 :
				POS_W'(signed'(rounded[ACC_W-1:FRAC_W]));
		end
	end

	assign rounded = acc_q + ACC_W'(1 << (FRAC_W - 1));

	assign done   = done_q;
	assign result = result_q;

	`BVR_ASSERT_IMP(a_done_after_fin, clk, arst_n, done, $past(state_q == ST_FIN), "done without finish")
	`BVR_ASSERT_NXT(a_query_busy, clk, arst_n, query_in, busy, "query did not raise busy")
	`BVR_ASSERT_IMP(a_mode_bound, clk, arst_n, state_q == ST_RUN, mode_q < n_max || mode_q == '0, "mode counter past limit")

endmodule

`default_nettype wire

// File: verif/tb_blendshape_vertex_reconstruct.sv
// Testbench for blendshape_vertex_reconstruct: drives request items and register writes,
// predicts each query result from its own copy of the stores and checks it at done.
// Depends on bvr_pkg and the block's RTL only.
module tb_blendshape_vertex_reconstruct;
	timeunit 1ns;
	timeprecision 1ps;
	import bvr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int POOL_SIZE    = 5;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam int QUIET_CYCLES = 8;
	localparam int TAIL_CYCLES  = 80;
	localparam longint CYCLE_LIMIT = 1_000_000;

	class reconstruct_tracker;
		shortint neutral_mem [MAX_ELEMENTS];
		shortint id_basis [BASIS_DEPTH];
		shortint ex_basis [BASIS_DEPTH];
		shortint id_coef [MAX_MODES];
		shortint ex_coef [MAX_MODES];
		int unsigned elem_count;
		int unsigned id_modes;
		int unsigned ex_modes;
		result_t pending [$];
		int unsigned failures;

		function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ELEMENT_COUNT: elem_count = 32'(data);
				CFG_IDENTITY_MODES: id_modes = 32'(data[MODE_CNT_W-1:0]);
				CFG_EXPRESSION_MODES: ex_modes = 32'(data[MODE_CNT_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint mode_sum(logic bank, int unsigned modes, int unsigned elem);
			longint acc;
			int unsigned used;
			acc = 0;
			used = (modes > MAX_MODES) ? MAX_MODES : modes;
			for (int unsigned m = 0; m < used; m++) begin
				if (bank == BANK_IDENTITY)
					acc += longint'(id_coef[m]) * longint'(id_basis[m * MAX_ELEMENTS + elem]);
				else
					acc += longint'(ex_coef[m]) * longint'(ex_basis[m * MAX_ELEMENTS + elem]);
			end
			return acc;
		endfunction

		function result_t reconstruct(req_t r);
			result_t res;
			longint acc;
			int unsigned count;
			int unsigned elem;
			elem = 32'(r.element_index);
			count = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
			res.element_out = r.element_index;
			res.position = '0;
			res.out_of_range = 1'b1;
			if (elem < count) begin
				acc = longint'(neutral_mem[elem]) <<< FRAC_W;
				acc += mode_sum(BANK_IDENTITY, id_modes, elem);
				acc += mode_sum(BANK_EXPRESSION, ex_modes, elem);
				acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
				if (acc > 64'sd2147483647)
					acc = 64'sd2147483647;
				if (acc < -64'sd2147483648)
					acc = -64'sd2147483648;
				res.position = acc[POS_W-1:0];
				res.out_of_range = 1'b0;
			end
			return res;
		endfunction

		function void take_request(req_t r);
			int unsigned addr;
			addr = int'(r.mode_index) * MAX_ELEMENTS + int'(r.element_index);
			case (r.req_type)
				REQ_NEUTRAL: neutral_mem[r.element_index] = r.value;
				REQ_BASIS: begin
					if (r.bank_select == BANK_IDENTITY)
						id_basis[addr] = r.value;
					else
						ex_basis[addr] = r.value;
				end
				REQ_COEFF: begin
					if (r.bank_select == BANK_IDENTITY)
						id_coef[r.mode_index] = r.value;
					else
						ex_coef[r.mode_index] = r.value;
				end
				REQ_QUERY: pending.insert(pending.size(), reconstruct(r));
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result for element %0d arrived with none expected", got.element_out);
				failures++;
			end else begin
				want = pending.pop_front();
				if (got.element_out !== want.element_out) begin
					$error("element_out expected %0d got %0d", want.element_out, got.element_out);
					failures++;
				end
				if (got.position !== want.position) begin
					$error("position expected %0d got %0d", want.position, got.position);
					failures++;
				end
				if (got.out_of_range !== want.out_of_range) begin
					$error("out_of_range expected %0d got %0d", want.out_of_range,
						got.out_of_range);
					failures++;
				end
			end
		endfunction

		function bit clean();
			return failures == 0 && pending.size() == 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	reconstruct_tracker tracker = new();
	int unsigned pool [POOL_SIZE];
	bit in_pool [MAX_ELEMENTS];
	bit gapless;

	blendshape_vertex_reconstruct dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(result);
	end

	initial begin
		longint cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("blendshape_vertex_reconstruct verification failed");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic req_t make_req(req_kind_t kind, logic bank, logic [MODE_W-1:0] mode,
			logic [ELEM_W-1:0] elem, logic signed [VAL_W-1:0] val);
		req_t r;
		r.req_type = kind;
		r.bank_select = bank;
		r.mode_index = mode;
		r.element_index = elem;
		r.value = val;
		return r;
	endfunction

	task automatic send_req(req_t r);
		int unsigned idle;
		if ($urandom_range(0, 39) == 0)
			gapless = !gapless;
		idle = gapless ? 0 : $urandom_range(0, 18);
		if (idle > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (busy);
		tracker.take_request(r);
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(logic [CFG_DATA_W-1:0] ec, int unsigned idm, int unsigned exm);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = CFG_ELEMENT_COUNT;
		idx[1] = CFG_IDENTITY_MODES;
		idx[2] = CFG_EXPRESSION_MODES;
		idx[3] = CFG_SPARE;
		val[0] = ec;
		val[1] = CFG_DATA_W'($urandom);
		val[1][MODE_CNT_W-1:0] = MODE_CNT_W'(idm);
		val[2] = CFG_DATA_W'($urandom);
		val[2][MODE_CNT_W-1:0] = MODE_CNT_W'(exm);
		val[3] = CFG_DATA_W'($urandom);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			tracker.set_config(idx[i], val[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// fill neutral and every basis entry of the pool elements so queries never read junk
	task automatic load_pool();
		logic signed [VAL_W-1:0] fill;
		bit extreme;
		for (int p = 0; p < POOL_SIZE; p++) begin
			extreme = pool[p] == 0 || pool[p] == MAX_ELEMENTS - 1;
			fill = (pool[p] == 0) ? 16'sh8000 : 16'sh7fff;
			send_req(make_req(REQ_NEUTRAL, 1'($urandom), MODE_W'($urandom), ELEM_W'(pool[p]),
				extreme ? fill : rand_value()));
			for (int m = 0; m < MAX_MODES; m++) begin
				send_req(make_req(REQ_BASIS, BANK_IDENTITY, MODE_W'(m), ELEM_W'(pool[p]),
					extreme ? fill : rand_value()));
				send_req(make_req(REQ_BASIS, BANK_EXPRESSION, MODE_W'(m), ELEM_W'(pool[p]),
					extreme ? fill : rand_value()));
			end
		end
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned elem;
		int unsigned count;
		pick = $urandom_range(0, 99);
		elem = $urandom_range(0, MAX_ELEMENTS - 1);
		count = (tracker.elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : tracker.elem_count;
		if (pick < 35) begin
			if ($urandom_range(0, 9) < 7 || (elem < count && !in_pool[elem]))
				elem = pool[$urandom_range(0, POOL_SIZE - 1)];
			send_req(make_req(REQ_QUERY, 1'($urandom), MODE_W'($urandom), ELEM_W'(elem),
				VAL_W'($urandom)));
		end else if (pick < 60) begin
			send_req(make_req(REQ_COEFF, 1'($urandom), MODE_W'($urandom), ELEM_W'(elem),
				rand_value()));
		end else if (pick < 85) begin
			if ($urandom_range(0, 9) < 7)
				elem = pool[$urandom_range(0, POOL_SIZE - 1)];
			send_req(make_req(REQ_BASIS, 1'($urandom), MODE_W'($urandom), ELEM_W'(elem),
				rand_value()));
		end else begin
			if ($urandom_range(0, 9) < 7)
				elem = pool[$urandom_range(0, POOL_SIZE - 1)];
			send_req(make_req(REQ_NEUTRAL, 1'($urandom), MODE_W'($urandom), ELEM_W'(elem),
				rand_value()));
		end
	endtask

	initial begin
		int unsigned ec;
		int unsigned idm;
		int unsigned exm;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ELEMENT_COUNT;
		cfg_data = '0;
		gapless = 1'b0;

		pool[0] = 0;
		pool[1] = 1;
		pool[2] = 2;
		pool[3] = MAX_ELEMENTS - 1;
		for (int p = 0; p < 4; p++)
			in_pool[pool[p]] = 1'b1;
		for (int p = 4; p < POOL_SIZE; p++) begin
			do begin
				pool[p] = $urandom_range(3, MAX_ELEMENTS - 2);
			end while (in_pool[pool[p]]);
			in_pool[pool[p]] = 1'b1;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration: everything out of range
		send_req(make_req(REQ_QUERY, BANK_EXPRESSION, MODE_W'(MAX_MODES - 1),
			ELEM_W'(MAX_ELEMENTS - 1), 16'shffff));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, '0, '0));

		load_pool();
		settle();
		program_regs(CFG_DATA_W'(MAX_ELEMENTS), MAX_MODES, MAX_MODES);

		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, '0, '0));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(MAX_ELEMENTS - 1), '0));
		for (int m = 0; m < MAX_MODES; m++) begin
			send_req(make_req(REQ_COEFF, BANK_IDENTITY, MODE_W'(m), ELEM_W'($urandom),
				16'sh8000));
			send_req(make_req(REQ_COEFF, BANK_EXPRESSION, MODE_W'(m), ELEM_W'($urandom),
				16'sh8000));
		end
		send_req(make_req(REQ_QUERY, BANK_EXPRESSION, '1, '0, '1));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(MAX_ELEMENTS - 1), '0));
		send_req(make_req(REQ_COEFF, BANK_IDENTITY, MODE_W'(MAX_MODES - 1), '1, 16'sh7fff));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(MAX_ELEMENTS - 1), '0));
		send_req(make_req(REQ_NEUTRAL, BANK_EXPRESSION, MODE_W'(5), ELEM_W'(MAX_ELEMENTS - 1),
			'0));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(MAX_ELEMENTS - 1), '0));
		send_req(make_req(REQ_BASIS, BANK_EXPRESSION, '0, ELEM_W'(MAX_ELEMENTS - 1), 16'sd1));
		send_req(make_req(REQ_COEFF, BANK_EXPRESSION, '0, ELEM_W'(MAX_ELEMENTS - 1), '0));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(MAX_ELEMENTS - 1), '0));

		// rounding: single identity mode, products on and just past the half-step boundary
		settle();
		program_regs(CFG_DATA_W'(MAX_ELEMENTS), 1, 0);
		send_req(make_req(REQ_COEFF, BANK_IDENTITY, '0, '0, 16'sd1));
		send_req(make_req(REQ_NEUTRAL, BANK_IDENTITY, '0, ELEM_W'(2), '0));
		send_req(make_req(REQ_BASIS, BANK_IDENTITY, '0, ELEM_W'(2), 16'sd2048));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(2), '0));
		send_req(make_req(REQ_BASIS, BANK_IDENTITY, '0, ELEM_W'(2), -16'sd2048));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(2), '0));
		send_req(make_req(REQ_BASIS, BANK_IDENTITY, '0, ELEM_W'(2), -16'sd2049));
		send_req(make_req(REQ_QUERY, BANK_IDENTITY, '0, ELEM_W'(2), '0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ec = 2047; idm = 127; exm = 127; end
				1: begin ec = 0; idm = 0; exm = 0; end
				2: begin ec = 3; idm = 1; exm = 0; end
				3: begin ec = MAX_ELEMENTS - 1; idm = 0; exm = MAX_MODES; end
				4: begin ec = MAX_ELEMENTS; idm = MAX_MODES; exm = 1; end
				default: begin
					ec = $urandom_range(0, 2047);
					idm = $urandom_range(0, 127);
					exm = $urandom_range(0, 127);
				end
			endcase
			settle();
			program_regs(CFG_DATA_W'(ec), idm, exm);
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.clean())
			$display("blendshape_vertex_reconstruct verification clean");
		else
			$display("blendshape_vertex_reconstruct verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bvr_pkg.sv
rtl/core/bvr_ram.sv
rtl/core/bvr_coef_bank.sv
rtl/core/blendshape_vertex_reconstruct.sv
verif/tb_blendshape_vertex_reconstruct.sv
